// ===== sv/swept_sphere_history_point_filter_top_defines.svh =====
// Assertion macros shared by the RTL
`ifndef SWEPT_SPHERE_HISTORY_POINT_FILTER_TOP_DEFINES_SVH
`define SWEPT_SPHERE_HISTORY_POINT_FILTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define SSHPF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("sshpf check failed");
`define SSHPF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sshpf check failed");
`else
`define SSHPF_ASSERT(lbl, prop)
`define SSHPF_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// ===== sv/sshpf_pkg.sv =====
package sshpf_pkg;
	localparam int POS_W   = 18;
	localparam int DIFF_W  = 19;
	localparam int SQ_W    = 38;
	localparam int RAD_W   = 16;
	localparam int RSQ_W   = 32;
	localparam int STAMP_W = 32;
	localparam int PROJ_W  = 40;
	localparam int HALF_W  = 19;
	localparam int PROD_W  = 76;
	localparam int IN_W    = 136;
	localparam int OUT_W   = 56;
	localparam int DUR_W   = 16;
	localparam logic [DUR_W-1:0] DUR_RESET = 16'd1500;

	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [SQ_W-1:0]   sprod_t;
	typedef logic [SQ_W-1:0]          sq_t;
	typedef logic signed [PROJ_W-1:0] proj_t;
	typedef logic [HALF_W-1:0]        half_t;
	typedef logic [PROD_W-1:0]        prod_t;
	typedef logic [RSQ_W-1:0]         rsq_t;
endpackage

// ===== sv/sshpf_mul.sv =====
module sshpf_mul (
	input  logic            clk,
	input  logic            en,
	input  sshpf_pkg::sq_t  a,
	input  sshpf_pkg::sq_t  b,
	output sshpf_pkg::prod_t p
);
	import sshpf_pkg::*;

	sq_t   pll_s1, plh_s1, phl_s1, phh_s1;
	prod_t p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pll_s1 <= sq_t'(a[HALF_W-1:0] * b[HALF_W-1:0]);
			plh_s1 <= sq_t'(a[HALF_W-1:0] * b[SQ_W-1:HALF_W]);
			phl_s1 <= sq_t'(a[SQ_W-1:HALF_W] * b[HALF_W-1:0]);
			phh_s1 <= sq_t'(a[SQ_W-1:HALF_W] * b[SQ_W-1:HALF_W]);
			p_s2 <= (prod_t'(phh_s1) << (2 * HALF_W))
				+ ((prod_t'(plh_s1) + prod_t'(phl_s1)) << HALF_W)
				+ prod_t'(pll_s1);
		end
	end

	assign p = p_s2;
endmodule

// ===== sv/swept_sphere_history_point_filter_top.sv =====
// Swept-sphere history point filter.
// Slave stream: tuser selects the request (0 frame start, 1 point); tdata carries
// the position, sphere radius, push and clear flags and the two stamps.
// Master stream: points that lie outside every stored sphere and capsule.
// cfg_wen/cfg_wdata write the history duration (ms); write only when idle.
// Points: one request per cycle while the master stream is not stalled and no frame
// start is pending; the result sits in the output register after stages s1 to s7.
// Every ring slot has its own lane of multipliers, so the rate does not depend on
// how many spheres are held.
// Frame start: waits for the point pipeline to drain, then clears the ring when the
// frame changed and writes the pushed sphere, sets up its capsule to the previous
// sphere, and prunes aged entries, oldest first; no point is taken meanwhile.
// Reset empties the ring and sets the duration to 1500 ms; no clearing pass.
// A stalled master stream holds the whole pipeline; nothing is lost or repeated.
module swept_sphere_history_point_filter_top #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// pos_x, pos_y, pos_z, sphere_radius, has_sphere, frame_changed,
	// sphere_stamp_ms, frame_stamp_ms
	input  logic [135:0] s_axis_tdata,
	// req_type
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_x, out_y, out_z, zero pad
	output logic [55:0] m_axis_tdata,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata
);
	import sshpf_pkg::*;
	`include "swept_sphere_history_point_filter_top_defines.svh"

	localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OW = HW + 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DRAIN = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_LEN   = 3'd3;
	localparam logic [2:0] ST_PRUNE = 3'd4;

	function automatic logic [HW-1:0] ring_wrap(input logic [OW-1:0] v);
		logic [OW-1:0] r;
		r = (v >= OW'(DEPTH)) ? v - OW'(DEPTH) : v;
		return r[HW-1:0];
	endfunction

	// control
	logic [2:0]       state_q;
	logic [HW-1:0]    head_q;
	logic [CW-1:0]    count_q;
	logic [DUR_W-1:0] dur_q;
	logic [HW-1:0]    widx_q;

	// frame start request
	logic                fs_fc_q, fs_has_q;
	pos_t                fs_x_q, fs_y_q, fs_z_q;
	logic [RAD_W-1:0]    fs_rad_q, prad_q;
	logic [STAMP_W-1:0]  fs_sstamp_q, fs_fstamp_q;
	diff_t               enx_q, eny_q, enz_q;

	// ring
	pos_t               cx_q [DEPTH];
	pos_t               cy_q [DEPTH];
	pos_t               cz_q [DEPTH];
	logic [RAD_W-1:0]   rad_q [DEPTH];
	logic [STAMP_W-1:0] stamp_q [DEPTH];
	rsq_t               rsq_q [DEPTH];
	rsq_t               rmax2_q [DEPTH];
	diff_t              ex_q [DEPTH];
	diff_t              ey_q [DEPTH];
	diff_t              ez_q [DEPTH];
	sq_t                len_q [DEPTH];

	// point pipeline
	logic en, acc, busy;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	pos_t px_s1, py_s1, pz_s1, px_s2, py_s2, pz_s2, px_s3, py_s3, pz_s3;
	pos_t px_s4, py_s4, pz_s4, px_s5, py_s5, pz_s5, px_s6, py_s6, pz_s6;
	pos_t px_s7, py_s7, pz_s7;
	diff_t  dx_s2 [DEPTH];
	diff_t  dy_s2 [DEPTH];
	diff_t  dz_s2 [DEPTH];
	sq_t    sqx_s3 [DEPTH];
	sq_t    sqy_s3 [DEPTH];
	sq_t    sqz_s3 [DEPTH];
	sprod_t prx_s3 [DEPTH];
	sprod_t pry_s3 [DEPTH];
	sprod_t prz_s3 [DEPTH];
	sq_t    d2_s4 [DEPTH];
	proj_t  proj_s4 [DEPTH];
	logic [DEPTH-1:0] sph_s5, pair_s5, le0_s5, gel_s5, s2ok_s5, e2ok_s5;
	logic [DEPTH-1:0] pair_s6, le0_s6, gel_s6, s2ok_s6, e2ok_s6;
	logic             sph_s6, hit_s7;
	prod_t  pa_s6 [DEPTH];
	prod_t  pb_s6 [DEPTH];
	prod_t  pc_s6 [DEPTH];
	logic [DEPTH-1:0] cap_c, lane_ok, first_c;
	logic [OW-1:0]    off_c [DEPTH];
	logic             m_valid_q;
	pos_t             mx_q, my_q, mz_q;

	// load and prune decisions
	logic [HW-1:0]      ld_head, ld_idx, ld_prev;
	logic [CW-1:0]      ld_count;
	logic [STAMP_W-1:0] age_c;
	logic               old_c;

	assign en = !m_valid_q || m_axis_tready;
	assign s_axis_tready = en && (state_q == ST_IDLE);
	assign acc = s_axis_tvalid && s_axis_tready;
	assign busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || v_s6 || v_s7;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			off_c[i] = OW'(i) + OW'(DEPTH) - OW'(head_q);
			if (off_c[i] >= OW'(DEPTH))
				off_c[i] = off_c[i] - OW'(DEPTH);
			lane_ok[i] = off_c[i] < OW'(count_q);
			first_c[i] = off_c[i] == '0;
		end
	end

	always_comb begin
		ld_head = fs_fc_q ? '0 : head_q;
		ld_count = fs_fc_q ? '0 : count_q;
		ld_idx = ld_head;
		if (fs_has_q) begin
			if (ld_count < CW'(DEPTH)) begin
				ld_idx = ring_wrap(OW'(ld_head) + OW'(ld_count));
				ld_count = ld_count + 1'b1;
			end else begin
				ld_idx = ld_head;
				ld_head = ring_wrap(OW'(ld_head) + OW'(1));
			end
		end
		ld_prev = (ld_idx == '0) ? HW'(DEPTH - 1) : ld_idx - 1'b1;
		age_c = fs_fstamp_q - stamp_q[head_q];
		old_c = $signed(age_c) > $signed({16'd0, dur_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			count_q <= '0;
			dur_q <= DUR_RESET;
			widx_q <= '0;
		end else begin
			if (cfg_wen)
				dur_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: begin
					if (acc && !s_axis_tuser)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!busy)
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					head_q <= ld_head;
					count_q <= ld_count;
					widx_q <= ld_idx;
					state_q <= fs_has_q ? ST_LEN : ST_PRUNE;
				end
				ST_LEN: begin
					state_q <= ST_PRUNE;
				end
				ST_PRUNE: begin
					if (dur_q == '0) begin
						if (count_q > CW'(1)) begin
							head_q <= ring_wrap(OW'(head_q) + OW'(count_q) - OW'(1));
							count_q <= CW'(1);
						end
						state_q <= ST_IDLE;
					end else if (count_q != '0 && old_c) begin
						head_q <= ring_wrap(OW'(head_q) + OW'(1));
						count_q <= count_q - 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !s_axis_tuser) begin
			fs_x_q <= s_axis_tdata[17:0];
			fs_y_q <= s_axis_tdata[35:18];
			fs_z_q <= s_axis_tdata[53:36];
			fs_rad_q <= s_axis_tdata[69:54];
			fs_has_q <= s_axis_tdata[70];
			fs_fc_q <= s_axis_tdata[71];
			fs_sstamp_q <= s_axis_tdata[103:72];
			fs_fstamp_q <= s_axis_tdata[135:104];
		end
		if (state_q == ST_LOAD && fs_has_q) begin
			cx_q[ld_idx] <= fs_x_q;
			cy_q[ld_idx] <= fs_y_q;
			cz_q[ld_idx] <= fs_z_q;
			rad_q[ld_idx] <= fs_rad_q;
			stamp_q[ld_idx] <= fs_sstamp_q;
			rsq_q[ld_idx] <= RSQ_W'(fs_rad_q * fs_rad_q);
			ex_q[ld_idx] <= DIFF_W'(fs_x_q) - DIFF_W'(cx_q[ld_prev]);
			ey_q[ld_idx] <= DIFF_W'(fs_y_q) - DIFF_W'(cy_q[ld_prev]);
			ez_q[ld_idx] <= DIFF_W'(fs_z_q) - DIFF_W'(cz_q[ld_prev]);
			enx_q <= DIFF_W'(fs_x_q) - DIFF_W'(cx_q[ld_prev]);
			eny_q <= DIFF_W'(fs_y_q) - DIFF_W'(cy_q[ld_prev]);
			enz_q <= DIFF_W'(fs_z_q) - DIFF_W'(cz_q[ld_prev]);
			prad_q <= rad_q[ld_prev];
		end
		if (state_q == ST_LEN) begin
			len_q[widx_q] <= sq_t'(enx_q * enx_q) + sq_t'(eny_q * eny_q)
				+ sq_t'(enz_q * enz_q);
			rmax2_q[widx_q] <= (fs_rad_q > prad_q) ? RSQ_W'(fs_rad_q * fs_rad_q)
				: RSQ_W'(prad_q * prad_q);
		end
	end

	// point pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= acc && s_axis_tuser;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			m_valid_q <= v_s7 && !hit_s7;
		end
	end

	generate
		for (genvar g = 0; g < DEPTH; g++) begin : g_lane
			localparam int PRV = (g == 0) ? DEPTH - 1 : g - 1;
			sshpf_mul u_mul_a (.clk(clk), .en(en), .a(d2_s4[PRV]), .b(len_q[g]),
				.p(pa_s6[g]));
			sshpf_mul u_mul_b (.clk(clk), .en(en), .a(sq_t'(rmax2_q[g])),
				.b(len_q[g]), .p(pb_s6[g]));
			sshpf_mul u_mul_c (.clk(clk), .en(en), .a(proj_s4[g][SQ_W-1:0]),
				.b(proj_s4[g][SQ_W-1:0]), .p(pc_s6[g]));
			always_ff @(posedge clk) begin
				if (en) begin
					dx_s2[g] <= DIFF_W'(px_s1) - DIFF_W'(cx_q[g]);
					dy_s2[g] <= DIFF_W'(py_s1) - DIFF_W'(cy_q[g]);
					dz_s2[g] <= DIFF_W'(pz_s1) - DIFF_W'(cz_q[g]);
					sqx_s3[g] <= sq_t'(dx_s2[g] * dx_s2[g]);
					sqy_s3[g] <= sq_t'(dy_s2[g] * dy_s2[g]);
					sqz_s3[g] <= sq_t'(dz_s2[g] * dz_s2[g]);
					prx_s3[g] <= sprod_t'(dx_s2[PRV] * ex_q[g]);
					pry_s3[g] <= sprod_t'(dy_s2[PRV] * ey_q[g]);
					prz_s3[g] <= sprod_t'(dz_s2[PRV] * ez_q[g]);
					d2_s4[g] <= sqx_s3[g] + sqy_s3[g] + sqz_s3[g];
					proj_s4[g] <= proj_t'(prx_s3[g]) + proj_t'(pry_s3[g])
						+ proj_t'(prz_s3[g]);
					sph_s5[g] <= lane_ok[g] && (d2_s4[g] <= sq_t'(rsq_q[g]));
					pair_s5[g] <= lane_ok[g] && !first_c[g] && (len_q[g] != '0);
					le0_s5[g] <= proj_s4[g] <= proj_t'(0);
					gel_s5[g] <= proj_s4[g] >= proj_t'({2'b00, len_q[g]});
					s2ok_s5[g] <= d2_s4[PRV] <= sq_t'(rmax2_q[g]);
					e2ok_s5[g] <= d2_s4[g] <= sq_t'(rmax2_q[g]);
					pair_s6[g] <= pair_s5[g];
					le0_s6[g] <= le0_s5[g];
					gel_s6[g] <= gel_s5[g];
					s2ok_s6[g] <= s2ok_s5[g];
					e2ok_s6[g] <= e2ok_s5[g];
				end
			end
			always_comb begin
				if (!pair_s6[g])
					cap_c[g] = 1'b0;
				else if (le0_s6[g])
					cap_c[g] = s2ok_s6[g];
				else if (gel_s6[g])
					cap_c[g] = e2ok_s6[g];
				else
					cap_c[g] = {1'b0, pa_s6[g]} <= ({1'b0, pb_s6[g]} + {1'b0, pc_s6[g]});
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= s_axis_tdata[17:0];
			py_s1 <= s_axis_tdata[35:18];
			pz_s1 <= s_axis_tdata[53:36];
			px_s2 <= px_s1; py_s2 <= py_s1; pz_s2 <= pz_s1;
			px_s3 <= px_s2; py_s3 <= py_s2; pz_s3 <= pz_s2;
			px_s4 <= px_s3; py_s4 <= py_s3; pz_s4 <= pz_s3;
			px_s5 <= px_s4; py_s5 <= py_s4; pz_s5 <= pz_s4;
			px_s6 <= px_s5; py_s6 <= py_s5; pz_s6 <= pz_s5;
			px_s7 <= px_s6; py_s7 <= py_s6; pz_s7 <= pz_s6;
			sph_s6 <= |sph_s5;
			hit_s7 <= sph_s6 || (|cap_c);
			mx_q <= px_s7;
			my_q <= py_s7;
			mz_q <= pz_s7;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {2'b00, mz_q, my_q, mx_q};

	`SSHPF_ASSERT(a_count_bound, count_q <= CW'(DEPTH))
	`SSHPF_ASSERT_IMP(a_ready_idle, s_axis_tready, state_q == ST_IDLE)
	`SSHPF_ASSERT_IMP(a_load_empty, state_q == ST_LOAD, !busy)
	`SSHPF_ASSERT_IMP(a_count_seq, count_q != $past(count_q),
		$past(state_q) == ST_LOAD || $past(state_q) == ST_PRUNE)
endmodule
